// File: rtl/core/bsl_pkg.sv
// Shared types and constants for the battery supervisor status light.
package bsl_pkg;

	// Field and register widths.
	localparam int CFG_W    = 13;
	localparam int CELL_W   = 5;
	localparam int BLINK_W  = 10;
	localparam int IDX_W    = 3;
	localparam int VOLT_W   = 16;
	localparam int PCT_W    = 7;
	localparam int LVL_W    = 2;
	localparam int COLOR_W  = 2;

	// A per-cell voltage times the cell count.
	localparam int SCALED_W = 18;
	// Signed pack voltage above the dead point.
	localparam int NUM_W    = 19;
	// That difference times one hundred.
	localparam int PROD_W   = 23;

	// Serial divider quotient.
	localparam int QUO_W     = 16;
	localparam int QBIT_W    = 4;
	localparam int PCT_QBITS = 8;
	localparam logic [QBIT_W-1:0] PCT_TOP_BIT = 4'd7;
	localparam logic [QBIT_W-1:0] AVG_TOP_BIT = 4'd15;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;
	localparam logic [PCT_W-1:0] PCT_MUL  = 7'd100;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_FULL   = 3'd0;
	localparam logic [IDX_W-1:0] REG_LOW    = 3'd1;
	localparam logic [IDX_W-1:0] REG_CRIT   = 3'd2;
	localparam logic [IDX_W-1:0] REG_DEAD   = 3'd3;
	localparam logic [IDX_W-1:0] REG_CELLS  = 3'd4;
	localparam logic [IDX_W-1:0] REG_NOBAT  = 3'd5;
	localparam logic [IDX_W-1:0] REG_BLINK  = 3'd6;

	// Register reset values.
	localparam logic [CFG_W-1:0]   RST_FULL  = 13'd4200;
	localparam logic [CFG_W-1:0]   RST_LOW   = 13'd3600;
	localparam logic [CFG_W-1:0]   RST_CRIT  = 13'd3400;
	localparam logic [CFG_W-1:0]   RST_DEAD  = 13'd3200;
	localparam logic [CELL_W-1:0]  RST_CELLS = 5'd1;
	localparam logic [BLINK_W-1:0] RST_BLINK = 10'd50;

	// Warning levels.
	localparam logic [LVL_W-1:0] LVL_NORMAL = 2'd0;
	localparam logic [LVL_W-1:0] LVL_LOW    = 2'd1;
	localparam logic [LVL_W-1:0] LVL_CRIT   = 2'd2;
	localparam logic [LVL_W-1:0] LVL_DEAD   = 2'd3;

	typedef enum logic [1:0] {
		CMD_SAMPLE  = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_ENABLE  = 2'd2,
		CMD_DISABLE = 2'd3
	} cmd_t;

	typedef enum logic [COLOR_W-1:0] {
		COLOR_NO_LINK = 2'd0,
		COLOR_FAULT   = 2'd1,
		COLOR_WARN    = 2'd2,
		COLOR_HEALTHY = 2'd3
	} color_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SCALE,
		ST_CHECK,
		ST_PDIV,
		ST_ADIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                start;
		logic [QBIT_W-1:0]   top_bit;
	} div_req_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
		logic e_stop;
	} light_cmd_t;

	typedef struct packed {
		logic enabled;
		logic fault;
		logic lamp_on;
	} light_stat_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic scale;
		logic check;
		logic pct_load;
		logic avg_load;
		logic out_load;
		logic avg_sel;
	} ctl_t;

endpackage

// File: rtl/core/bsl_window_mem.sv
// Sample window memory with one write port and one registered read port.
module bsl_window_mem
	import bsl_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [VOLT_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [VOLT_W-1:0] rd_data
);

	logic [VOLT_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/bsl_divider.sv
// Shared restoring divider that retires one quotient bit per cycle.
module bsl_divider
	import bsl_pkg::*;
#(
	parameter int DVD_W = 23,
	parameter int DVS_W = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [QUO_W-1:0] quotient
);

	localparam int SH_W  = DVS_W + QUO_W;
	localparam int CMP_W = (DVD_W > SH_W) ? DVD_W : SH_W;

	logic [DVD_W-1:0]  rem_q;
	logic [SH_W-1:0]   sh_q;
	logic [QUO_W-1:0]  quo_q;
	logic [QBIT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [CMP_W-1:0]  rem_x;
	logic [CMP_W-1:0]  sh_x;
	logic [CMP_W-1:0]  diff;
	logic              fits;

	assign rem_x = CMP_W'(rem_q);
	assign sh_x  = CMP_W'(sh_q);
	assign fits  = rem_x >= sh_x;
	assign diff  = rem_x - sh_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.top_bit;
		end else if (busy_q) begin
			done_q <= (cnt_q == '0);
			busy_q <= (cnt_q != '0);
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The divisor starts aligned under the top quotient bit and walks right.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= dividend;
			sh_q  <= SH_W'(divisor) << req.top_bit;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= diff[DVD_W-1:0];
			end
			quo_q <= {quo_q[QUO_W-2:0], fits};
			sh_q  <= sh_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/core/bsl_light.sv
// Enable, fault and blink state behind the status light.
module bsl_light
	import bsl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  light_cmd_t         cmd_in,
	input  logic [BLINK_W-1:0] blink_period,
	output light_stat_t        stat
);

	logic               enabled_q;
	logic               fault_q;
	logic               lamp_q;
	logic [BLINK_W-1:0] phase_q;
	logic [BLINK_W:0]   phase_inc;
	logic               wrap;

	assign phase_inc = {1'b0, phase_q} + 1'b1;
	// A zero period wraps on every tick, the same as a period of one.
	assign wrap      = phase_inc >= {1'b0, blink_period};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			fault_q   <= 1'b0;
			lamp_q    <= 1'b1;
			phase_q   <= '0;
		end else if (cmd_in.valid) begin
			unique case (cmd_in.cmd)
				CMD_TICK: begin
					if (enabled_q) begin
						if (wrap) begin
							phase_q <= '0;
							lamp_q  <= ~lamp_q;
						end else begin
							phase_q <= phase_inc[BLINK_W-1:0];
						end
					end
				end
				CMD_ENABLE: begin
					enabled_q <= 1'b1;
				end
				CMD_DISABLE: begin
					enabled_q <= 1'b0;
					phase_q   <= '0;
					fault_q   <= cmd_in.e_stop;
					lamp_q    <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign stat.enabled = enabled_q;
	assign stat.fault   = fault_q;
	assign stat.lamp_on = lamp_q;

endmodule

// File: rtl/core/battery_supervisor_status_light_top.sv
// Top level of the battery supervisor with status light.
//
// Channel   | Handshake            | Payload
// ----------+----------------------+----------------------------------------------
// input     | in_valid / in_ready  | cmd, voltage_mv, e_stop, ds_present
// result    | out_valid / out_ready| percent, average_mv, warn_level,
//           |                      | disable_request, light_color, light_on,
//           |                      | is_enabled
// config    | cfg_write            | cfg_index, cfg_data (write only)
//
// One transaction is worked on at a time. A voltage sample passes through a window
// memory read and update, the scaling multiplies, then the shared serial divider,
// 8 steps for the charge percentage and 16 steps for the rolling average. When the
// percentage needs no division (at or below dead, saturated, degenerate thresholds)
// only the rolling average division is run. Tick, enable, disable and samples with
// no battery go straight to the result register.
// The result register holds a finished transaction until it is taken; a stalled
// result blocks the next one from completing but not from being accepted.
// Reset is asynchronous and active low; the window memory needs no clearing pass
// since the old value of an entry is used only after it has been written.
module battery_supervisor_status_light_top
	import bsl_pkg::*;
#(
	parameter int WINDOW = 16
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_write,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [VOLT_W-1:0]  voltage_mv,
	input  logic               e_stop,
	input  logic               ds_present,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [PCT_W-1:0]   percent,
	output logic [VOLT_W-1:0]  average_mv,
	output logic [LVL_W-1:0]   warn_level,
	output logic               disable_request,
	output logic [COLOR_W-1:0] light_color,
	output logic               light_on,
	output logic               is_enabled
);

	// Window bookkeeping widths follow the window length.
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = VOLT_W + $clog2(WINDOW);
	localparam int THR_W  = SCALED_W + CNT_W;
	localparam int LV_W   = (SUM_W > THR_W) ? SUM_W : THR_W;
	localparam int OVF_W  = SCALED_W + PCT_QBITS;
	localparam int DVD_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;
	localparam int DVS_W  = (SCALED_W > CNT_W) ? SCALED_W : CNT_W;
	localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0]  WINDOW_CNT = CNT_W'(WINDOW);

	// Configuration registers.
	logic [CFG_W-1:0]   cfg_full_q;
	logic [CFG_W-1:0]   cfg_low_q;
	logic [CFG_W-1:0]   cfg_crit_q;
	logic [CFG_W-1:0]   cfg_dead_q;
	logic [CELL_W-1:0]  cfg_cells_q;
	logic               cfg_nobat_q;
	logic [BLINK_W-1:0] cfg_blink_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_full_q  <= RST_FULL;
			cfg_low_q   <= RST_LOW;
			cfg_crit_q  <= RST_CRIT;
			cfg_dead_q  <= RST_DEAD;
			cfg_cells_q <= RST_CELLS;
			cfg_nobat_q <= 1'b0;
			cfg_blink_q <= RST_BLINK;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FULL:  cfg_full_q  <= cfg_data;
				REG_LOW:   cfg_low_q   <= cfg_data;
				REG_CRIT:  cfg_crit_q  <= cfg_data;
				REG_DEAD:  cfg_dead_q  <= cfg_data;
				REG_CELLS: cfg_cells_q <= cfg_data[CELL_W-1:0];
				REG_NOBAT: cfg_nobat_q <= cfg_data[0];
				REG_BLINK: cfg_blink_q <= cfg_data[BLINK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer state and control.
	state_t   state_q;
	state_t   state_d;
	ctl_t     ctl;
	div_req_t div_req;
	logic     sample_go;
	logic     need_pdiv;
	logic     div_done;
	logic     out_free;
	logic     out_valid_q;

	assign sample_go = (cmd_t'(cmd) == CMD_SAMPLE) && !cfg_nobat_q;
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sample_go ? ST_UPDATE : ST_DONE;
				end
			end
			ST_UPDATE: state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_CHECK;
			ST_CHECK:  state_d = need_pdiv ? ST_PDIV : ST_ADIV;
			ST_PDIV: begin
				if (div_done) begin
					state_d = ST_ADIV;
				end
			end
			ST_ADIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl             = '0;
		div_req.start   = 1'b0;
		div_req.top_bit = AVG_TOP_BIT;
		in_ready        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				ctl.accept = in_valid;
			end
			ST_UPDATE: ctl.update = 1'b1;
			ST_SCALE:  ctl.scale  = 1'b1;
			ST_CHECK: begin
				ctl.check       = 1'b1;
				ctl.avg_sel     = !need_pdiv;
				div_req.start   = 1'b1;
				div_req.top_bit = need_pdiv ? PCT_TOP_BIT : AVG_TOP_BIT;
			end
			ST_PDIV: begin
				ctl.pct_load  = div_done;
				ctl.avg_sel   = 1'b1;
				div_req.start = div_done;
			end
			ST_ADIV: ctl.avg_load = div_done;
			ST_DONE: ctl.out_load = out_free;
			default: begin
			end
		endcase
	end

	// Captured input fields.
	logic [VOLT_W-1:0] volt_q;
	logic              ds_q;

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			volt_q <= voltage_mv;
			ds_q   <= ds_present;
		end
	end

	// Window memory: the entry about to be replaced is read in the acceptance
	// cycle and overwritten in the following one, so the two never overlap.
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [VOLT_W-1:0] old_sample;
	logic              window_full;

	bsl_window_mem #(
		.DEPTH (WINDOW),
		.AW    (SLOT_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (ctl.update),
		.wr_addr (slot_q),
		.wr_data (volt_q),
		.rd_en   (ctl.accept),
		.rd_addr (slot_q),
		.rd_data (old_sample)
	);

	assign window_full = (count_q == WINDOW_CNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (ctl.update) begin
			sum_q   <= sum_q - (window_full ? SUM_W'(old_sample) : '0) + SUM_W'(volt_q);
			count_q <= window_full ? count_q : count_q + 1'b1;
			slot_q  <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
		end
	end

	// Thresholds scaled by the cell count, taken at acceptance.
	logic [SCALED_W-1:0] dead_n_q;
	logic [SCALED_W-1:0] den_q;
	logic [SCALED_W-1:0] low_n_q;
	logic [SCALED_W-1:0] crit_n_q;
	logic                den_zero_q;
	logic                den_neg_q;
	logic [CFG_W-1:0]    span;

	assign span = (cfg_full_q > cfg_dead_q) ? (cfg_full_q - cfg_dead_q) : '0;

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			dead_n_q   <= SCALED_W'(cfg_dead_q) * SCALED_W'(cfg_cells_q);
			den_q      <= SCALED_W'(span) * SCALED_W'(cfg_cells_q);
			low_n_q    <= SCALED_W'(cfg_low_q) * SCALED_W'(cfg_cells_q);
			crit_n_q   <= SCALED_W'(cfg_crit_q) * SCALED_W'(cfg_cells_q);
			den_zero_q <= (cfg_full_q == cfg_dead_q) || (cfg_cells_q == '0);
			den_neg_q  <= cfg_full_q < cfg_dead_q;
		end
	end

	// Voltage above the dead point, its percentage numerator, and the level
	// thresholds multiplied out by the number of samples held.
	logic signed [NUM_W-1:0] num_q;
	logic [PROD_W-1:0]       prod_q;
	logic [THR_W-1:0]        thr_low_q;
	logic [THR_W-1:0]        thr_crit_q;
	logic [THR_W-1:0]        thr_dead_q;

	always_ff @(posedge clk) begin
		if (ctl.update) begin
			num_q <= signed'({3'b000, volt_q}) - signed'({1'b0, dead_n_q});
		end
		if (ctl.scale) begin
			prod_q     <= PROD_W'(num_q[VOLT_W-1:0]) * PROD_W'(PCT_MUL);
			thr_low_q  <= THR_W'(low_n_q) * THR_W'(count_q);
			thr_crit_q <= THR_W'(crit_n_q) * THR_W'(count_q);
			thr_dead_q <= THR_W'(dead_n_q) * THR_W'(count_q);
		end
	end

	// Percentage cases that need no division.
	logic             num_pos;
	logic             pct_over;
	logic [PCT_W-1:0] pct_fixed;

	assign num_pos  = !num_q[NUM_W-1] && (num_q != '0);
	// A quotient that would not fit the eight divider steps is far above 100.
	assign pct_over = OVF_W'(prod_q) >= {den_q, {PCT_QBITS{1'b0}}};

	always_comb begin
		need_pdiv = 1'b0;
		priority if (!num_pos) begin
			pct_fixed = PCT_ZERO;
		end else if (den_zero_q) begin
			pct_fixed = PCT_FULL;
		end else if (den_neg_q) begin
			pct_fixed = PCT_ZERO;
		end else if (pct_over) begin
			pct_fixed = PCT_FULL;
		end else begin
			pct_fixed = PCT_ZERO;
			need_pdiv = 1'b1;
		end
	end

	// Supervisor results.
	logic [PCT_W-1:0]  pct_q;
	logic [VOLT_W-1:0] avg_q;
	logic [LVL_W-1:0]  lvl_q;
	logic              req_q;

	// Warning level: compares the exact average against the thresholds by
	// comparing the window sum with threshold times sample count.
	logic             above_low;
	logic             above_crit;
	logic             above_dead;
	logic [LVL_W-1:0] lvl_next;
	logic             req_next;

	assign above_low  = LV_W'(sum_q) > LV_W'(thr_low_q);
	assign above_crit = LV_W'(sum_q) > LV_W'(thr_crit_q);
	assign above_dead = LV_W'(sum_q) > LV_W'(thr_dead_q);

	always_comb begin
		lvl_next = lvl_q;
		req_next = 1'b0;
		if (above_low) begin
			lvl_next = LVL_NORMAL;
		end
		if (!above_low && (lvl_next < LVL_LOW)) begin
			lvl_next = LVL_LOW;
		end
		if (!above_crit && (lvl_next < LVL_CRIT)) begin
			lvl_next = LVL_CRIT;
		end
		if (!above_dead && (lvl_next < LVL_DEAD)) begin
			lvl_next = LVL_DEAD;
			req_next = 1'b1;
		end
	end

	// Shared divider: the percentage first when it needs a division, then the rolling average.
	logic [DVD_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic [QUO_W-1:0] div_quo;

	assign div_dividend = ctl.avg_sel ? DVD_W'(sum_q) : DVD_W'(prod_q);
	assign div_divisor  = ctl.avg_sel ? DVS_W'(count_q) : DVS_W'(den_q);

	bsl_divider #(
		.DVD_W (DVD_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= '0;
			avg_q <= '0;
			lvl_q <= LVL_NORMAL;
			req_q <= 1'b0;
		end else begin
			if (ctl.accept) begin
				req_q <= 1'b0;
				if ((cmd_t'(cmd) == CMD_SAMPLE) && cfg_nobat_q) begin
					pct_q <= PCT_FULL;
				end
			end
			if (ctl.check) begin
				lvl_q <= lvl_next;
				req_q <= req_next;
				if (!need_pdiv) begin
					pct_q <= pct_fixed;
				end
			end
			if (ctl.pct_load) begin
				pct_q <= (div_quo > QUO_W'(PCT_FULL)) ? PCT_FULL : div_quo[PCT_W-1:0];
			end
			if (ctl.avg_load) begin
				avg_q <= div_quo[VOLT_W-1:0];
			end
		end
	end

	// Enable, fault and blink state.
	light_cmd_t  light_cmd;
	light_stat_t light_stat;

	assign light_cmd.valid  = ctl.accept;
	assign light_cmd.cmd    = cmd_t'(cmd);
	assign light_cmd.e_stop = e_stop;

	bsl_light u_light (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_in       (light_cmd),
		.blink_period (cfg_blink_q),
		.stat         (light_stat)
	);

	// Light color by priority: link, fault, warning, healthy.
	color_t color;

	always_comb begin
		priority if (!ds_q) begin
			color = COLOR_NO_LINK;
		end else if (light_stat.fault) begin
			color = COLOR_FAULT;
		end else if (lvl_q != LVL_NORMAL) begin
			color = COLOR_WARN;
		end else begin
			color = COLOR_HEALTHY;
		end
	end

	// Result register.
	logic [PCT_W-1:0]   out_pct_q;
	logic [VOLT_W-1:0]  out_avg_q;
	logic [LVL_W-1:0]   out_lvl_q;
	logic               out_req_q;
	logic [COLOR_W-1:0] out_color_q;
	logic               out_lamp_q;
	logic               out_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_pct_q   <= pct_q;
			out_avg_q   <= avg_q;
			out_lvl_q   <= lvl_q;
			out_req_q   <= req_q;
			out_color_q <= color;
			out_lamp_q  <= light_stat.lamp_on;
			out_en_q    <= light_stat.enabled;
		end
	end

	assign out_valid       = out_valid_q;
	assign percent         = out_pct_q;
	assign average_mv      = out_avg_q;
	assign warn_level      = out_lvl_q;
	assign disable_request = out_req_q;
	assign light_color     = out_color_q;
	assign light_on        = out_lamp_q;
	assign is_enabled      = out_en_q;

endmodule

// File: rtl/core/bsl_checker.sv
// Port-level checks for the battery supervisor top level, bound to it.
module bsl_checker
	import bsl_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [PCT_W-1:0]   percent,
	input logic [VOLT_W-1:0]  average_mv,
	input logic [LVL_W-1:0]   warn_level,
	input logic               disable_request,
	input logic [COLOR_W-1:0] light_color
);

	// One transaction at a time: taking an input closes the input side.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a transaction is in progress");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(percent) && $stable(average_mv)
			&& $stable(warn_level) && $stable(light_color))
		else $error("stalled result changed or dropped");

	a_percent_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> percent <= 7'd100)
		else $error("percentage above 100");

	a_request_dead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && disable_request |-> warn_level == LVL_DEAD)
		else $error("disable request without dead level");

	a_color_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (light_color == COLOR_WARN || light_color == COLOR_HEALTHY)
			|-> ((light_color == COLOR_WARN) == (warn_level != LVL_NORMAL)))
		else $error("light color disagrees with warning level");

endmodule

bind battery_supervisor_status_light_top bsl_checker u_bsl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.percent         (percent),
	.average_mv      (average_mv),
	.warn_level      (warn_level),
	.disable_request (disable_request),
	.light_color     (light_color)
);
